// ===== src/segment_reorder_receiver_unit_macros.svh =====
// Assertion macros for the segment reorder receiver.
// Used by the datapath module; no other dependencies.
`ifndef SEGMENT_REORDER_RECEIVER_UNIT_MACROS_SVH
`define SEGMENT_REORDER_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SRR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srr: implication check failed");

// Next-cycle implication, disabled during reset
`define SRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srr: next-cycle check failed");

`endif

// ===== src/srr_pkg.sv =====
// Shared types and constants of the segment reorder receiver.
// Used by the controller, the datapath and the top level.
`default_nettype none

package srr_pkg;

   localparam int WINDOW  = 16;
   localparam int SLOT_W  = $clog2(WINDOW);
   localparam int KCNT_W  = $clog2(WINDOW + 1);

   localparam logic [15:0] CAPACITY_RESET = 16'(9 * 1024);
   localparam logic [16:0] BUFFERED_MAX   = 17'h1FFFF;

   // result kinds
   localparam logic [1:0] KIND_SEG   = 2'd0;
   localparam logic [1:0] KIND_ACK   = 2'd1;
   localparam logic [1:0] KIND_GRANT = 2'd2;

   // input operations
   localparam logic OP_SEGMENT = 1'b0;
   localparam logic OP_READ    = 1'b1;

   // register indexes
   localparam logic CSR_PROTOCOL_TAG    = 1'b0;
   localparam logic CSR_BUFFER_CAPACITY = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] seq;
      logic [15:0] claimed_len;
      logic [15:0] avail_len;
      logic [7:0]  proto_field;
      logic        is_data;
      logic        segment_ok;
      logic [15:0] request_bytes;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] seg_seq;
      logic [15:0] seg_len;
      logic [15:0] ack_num;
      logic [15:0] adv_window;
      logic [15:0] granted;
      logic        last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic store;
      logic emit_head;
      logic emit_drain;
      logic emit_ack;
      logic emit_grant;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_read;
      logic seg_accept;
      logic d_zero;
      logic d_window;
      logic slot_hit;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== src/segment_reorder_receiver_unit.sv =====
// Top level of the segment reorder receiver: joins the sequencer and the
// datapath. Depends on srr_pkg, srr_ctrl and srr_dp.
//
// Usage:
//   req_*  : one word per segment header or application read; taken when
//            req_valid is high and req_stall low.
//   rsp_*  : result words (delivered segment, ack, read grant); the final
//            word of an input carries last.
//   csr_*  : register writes (index 0 protocol tag, 1 buffer capacity); to be
//            written only while the block is idle, which it does not enforce.
// Sequencing: one word is worked at a time by the sequencer. An in-order
//   segment drains each following stored segment through the slot store's
//   registered read port, which is visited once per drained slot.
// Stall: a stalled result holds in the output register; the block may
//   accept a new word meanwhile but waits before emitting the next result.
// Reset: clears expected sequence, slot valid bits, byte count, result
//   valid and the registers to their defaults; there is no clearing pass.
`default_nettype none

module segment_reorder_receiver_unit
   import srr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   srr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   srr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

// ===== src/srr_ctrl.sv =====
// Sequencer of the segment reorder receiver: walks one word through evaluate,
// deliver, check, drain, ack and grant steps. Depends on srr_pkg.
`default_nettype none

module srr_ctrl
   import srr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DELIVER,
      ST_CHECK,
      ST_DRAIN,
      ST_ACK,
      ST_GRANT
   } state_type;

   state_type          state_ff, state_in;
   logic [KCNT_W-1:0]  k_ff, k_in;

   // take a new word only when idle
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.op_read) begin
               state_in = ST_GRANT;
            end else if (!sts.seg_accept) begin
               state_in = ST_IDLE;
            end else if (sts.d_zero) begin
               state_in = ST_DELIVER;
            end else if (sts.d_window) begin
               cmd.store = 1'b1;
               state_in  = ST_ACK;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_DELIVER: begin
            if (sts.out_free) begin
               cmd.emit_head = 1'b1;
               k_in          = KCNT_W'(1);
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // the slot read issued here is ready in the drain step
            if (sts.slot_hit && (k_ff < KCNT_W'(WINDOW))) begin
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_DRAIN: begin
            if (sts.out_free) begin
               cmd.emit_drain = 1'b1;
               k_in           = k_ff + KCNT_W'(1);
               state_in       = ST_CHECK;
            end
         end
         ST_ACK: begin
            if (sts.out_free) begin
               cmd.emit_ack = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_GRANT: begin
            if (sts.out_free) begin
               cmd.emit_grant = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and result count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/srr_dp.sv =====
// Datapath of the segment reorder receiver: registers, slot store, byte
// count and result register. Depends on srr_pkg and the macros header.
`default_nettype none

`include "segment_reorder_receiver_unit_macros.svh"

module srr_dp
   import srr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire req_type     req_data,
   output rsp_type          rsp_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire cmd_type     cmd,
   output sts_type          sts
);

   logic [7:0]        protocol_tag_ff;
   logic [15:0]       buffer_capacity_ff;
   req_type           req_ff;
   logic [15:0]       next_expected_ff, next_expected_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic [WINDOW-1:0] slot_valid_ff;
   logic [15:0]       slot_len_mem [WINDOW];
   logic [15:0]       slot_rd_ff;
   logic [16:0]       buffered_ff, buffered_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [15:0]       seg_len;
   logic [15:0]       seq_gap;
   logic [SLOT_W:0]   slot_sum;
   logic [SLOT_W-1:0] store_slot;
   logic [15:0]       add_len;
   logic [17:0]       add_sum;
   logic [15:0]       room;
   logic [15:0]       grant_n;
   logic              advance;
   logic [15:0]       seq_plus_one;
   logic [3:0]        emit_vec;
   logic              emit_any;

   // clamp length and window test
   assign seg_len  = (req_ff.claimed_len < req_ff.avail_len) ?
                     req_ff.claimed_len : req_ff.avail_len;
   assign seq_gap  = req_ff.seq - next_expected_ff;

   // slot of a stored sequence: offset from the pointer, or the raw low bits
   // when the sequence has wrapped past zero
   assign slot_sum = {1'b0, ptr_ff} + {1'b0, seq_gap[SLOT_W-1:0]};
   always_comb begin
      if (req_ff.seq < next_expected_ff) begin
         store_slot = req_ff.seq[SLOT_W-1:0];
      end else if (slot_sum >= (SLOT_W+1)'(WINDOW)) begin
         store_slot = SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW));
      end else begin
         store_slot = slot_sum[SLOT_W-1:0];
      end
   end

   // status to controller
   assign sts.op_read    = (req_ff.operation == OP_READ);
   assign sts.seg_accept = req_ff.segment_ok && req_ff.is_data &&
                           (req_ff.proto_field == protocol_tag_ff);
   assign sts.d_zero     = (seq_gap == 16'd0);
   assign sts.d_window   = (seq_gap < 16'(WINDOW));
   assign sts.slot_hit   = slot_valid_ff[ptr_ff];
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   // byte count, advertised window and grant
   assign add_len = cmd.emit_drain ? slot_rd_ff : seg_len;
   assign add_sum = {1'b0, buffered_ff} + {2'b00, add_len};
   assign room    = (buffered_ff >= {1'b0, buffer_capacity_ff}) ? 16'd0 :
                    (buffer_capacity_ff - buffered_ff[15:0]);
   assign grant_n = (buffered_ff < {1'b0, req_ff.request_bytes}) ?
                    buffered_ff[15:0] : req_ff.request_bytes;
   assign advance = cmd.emit_head || cmd.emit_drain;

   always_comb begin
      buffered_in = buffered_ff;
      if (advance) begin
         buffered_in = (add_sum > {1'b0, BUFFERED_MAX}) ? BUFFERED_MAX :
                       add_sum[16:0];
      end else if (cmd.emit_grant) begin
         buffered_in = buffered_ff - {1'b0, grant_n};
      end
   end

   // advance expected sequence and its slot pointer together
   assign seq_plus_one = next_expected_ff + 16'd1;
   always_comb begin
      next_expected_in = next_expected_ff;
      ptr_in           = ptr_ff;
      if (advance) begin
         next_expected_in = seq_plus_one;
         if (next_expected_ff == 16'hFFFF) begin
            ptr_in = '0;
         end else if (ptr_ff == SLOT_W'(WINDOW - 1)) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + SLOT_W'(1);
         end
      end
   end

   // build the result word
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_in         = '0;
         rsp_in.kind    = KIND_SEG;
         rsp_in.seg_seq = cmd.emit_drain ? next_expected_ff : req_ff.seq;
         rsp_in.seg_len = add_len;
         rsp_valid_in   = 1'b1;
      end else if (cmd.emit_ack) begin
         rsp_in            = '0;
         rsp_in.kind       = KIND_ACK;
         rsp_in.ack_num    = next_expected_ff;
         rsp_in.adv_window = room;
         rsp_in.last       = 1'b1;
         rsp_valid_in      = 1'b1;
      end else if (cmd.emit_grant) begin
         rsp_in         = '0;
         rsp_in.kind    = KIND_GRANT;
         rsp_in.granted = grant_n;
         rsp_in.last    = 1'b1;
         rsp_valid_in   = 1'b1;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_tag_ff    <= 8'd0;
         buffer_capacity_ff <= CAPACITY_RESET;
         next_expected_ff   <= '0;
         ptr_ff             <= '0;
         slot_valid_ff      <= '0;
         buffered_ff        <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PROTOCOL_TAG:    protocol_tag_ff    <= csr_wdata[7:0];
               CSR_BUFFER_CAPACITY: buffer_capacity_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         next_expected_ff <= next_expected_in;
         ptr_ff           <= ptr_in;
         buffered_ff      <= buffered_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (cmd.store) begin
            slot_valid_ff[store_slot] <= 1'b1;
         end else if (cmd.emit_drain) begin
            slot_valid_ff[ptr_ff] <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // slot length store, registered read at the pointer
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         slot_len_mem[store_slot] <= seg_len;
      end
      slot_rd_ff <= slot_len_mem[ptr_ff];
   end

   // gather the emit commands for the checks below
   assign emit_vec = {cmd.emit_head, cmd.emit_drain, cmd.emit_ack, cmd.emit_grant};
   assign emit_any = advance || cmd.emit_ack || cmd.emit_grant;

   `SRR_ASSERT_IMPL(a_one_emit, clock, reset, 1'b1, $onehot0(emit_vec))
   `SRR_ASSERT_IMPL(a_drain_hit, clock, reset, cmd.emit_drain, slot_valid_ff[ptr_ff])
   `SRR_ASSERT_NEXT(a_seq_step, clock, reset, advance, next_expected_ff == $past(seq_plus_one))
   `SRR_ASSERT_IMPL(a_emit_free, clock, reset, emit_any, sts.out_free)

endmodule

`default_nettype wire
